FILE: rtl/rfs_pkg.sv
`timescale 1ns / 1ps
// Package for the retry-and-fallback sequencer: request payload types, codes
// and mixing constants. No dependencies.
package rfs_pkg;

    localparam int MAX_BACKENDS_DEF = 16;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_BACKEND_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRY_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VALIDATION_RETRIES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_AFTER_CAP_MS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_AFTER_ENABLE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_AFTER_DELTAS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PRNG_SEED = 3'd6;

    localparam logic [4:0] BACKEND_COUNT_RST = 5'd1;
    localparam logic [7:0] TRY_LIMIT_RST = 8'd3;
    localparam logic [7:0] VALIDATION_RETRIES_RST = 8'd0;
    localparam logic [31:0] RETRY_AFTER_CAP_RST = 32'd60000;
    localparam logic RETRY_AFTER_ENABLE_RST = 1'b1;
    localparam logic RETRY_AFTER_DELTAS_RST = 1'b0;
    localparam logic [63:0] PRNG_SEED_RST = 64'd1;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_OUTCOME = 1'b1;

    localparam logic [2:0] CLS_SUCCESS = 3'd0;
    localparam logic [2:0] CLS_RETRY = 3'd1;
    localparam logic [2:0] CLS_ADVANCE = 3'd2;
    localparam logic [2:0] CLS_ABORT = 3'd3;
    localparam logic [2:0] CLS_CANCELLED = 3'd4;
    localparam logic [2:0] CLS_VALIDATOR = 3'd5;

    typedef enum logic [2:0] {
        ACT_STARTED  = 3'd0,
        ACT_WAIT     = 3'd1,
        ACT_REROLL   = 3'd2,
        ACT_NEXT     = 3'd3,
        ACT_FINISHED = 3'd4
    } rfs_action_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_ABORTED     = 3'd1,
        ST_CANCELLED   = 3'd2,
        ST_STREAM_LOST = 3'd3,
        ST_EXHAUSTED   = 3'd4,
        ST_NOMEM       = 3'd5
    } rfs_status_t;

    localparam logic [63:0] MIX_GOLDEN = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_MUL1 = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_MUL2 = 64'h94D049BB133111EB;
    localparam int MIX_SHIFT0 = 30;
    localparam int MIX_SHIFT1 = 27;
    localparam int MIX_SHIFT2 = 31;

    localparam int DIGIT_W = 4;
    localparam int MUL_DIGITS = 64 / DIGIT_W;
    localparam int DIG_CNT_W = $clog2(MUL_DIGITS);

    typedef struct packed {
        logic        command;
        logic [2:0]  fail_class;
        logic        out_of_memory;
        logic        delivered;
        logic        retry_after_present;
        logic [31:0] server_wait_ms;
    } rfs_in_t;

    typedef struct packed {
        rfs_action_t action;
        rfs_status_t final_status;
        logic [3:0]  backend_index;
        logic [31:0] attempt_number;
        logic [8:0]  backend_try;
        logic [31:0] wait_ms;
        logic        backoff_needed;
        logic [7:0]  retry_number;
        logic [63:0] jitter_word;
    } rfs_out_t;

endpackage

FILE: rtl/retry_fallback_sequencer.sv
`timescale 1ns / 1ps
// Retry-and-fallback sequencer top level: request decision, counters and a
// digit-serial splitmix64 mixer. Depends on rfs_pkg.
//
//   channel   | ports                         | handshake
//   ----------+-------------------------------+-----------------------------
//   request   | s_valid, s_ready, s_data      | valid/ready, rfs_in_t
//   result    | m_valid, m_ready, m_data      | valid/ready, rfs_out_t
//   config    | cfg_wr_en, cfg_index, cfg_wdata | write on enable, no wait
//
// A request is decided in the cycle it is taken, kept in a pending register;
// S_PUSH moves it to the output register once that is free. For a jitter
// word, S_MUL1 and S_MUL2 come first: the two 64-bit multiplies run one 4-bit
// digit per cycle through a shared shift-and-add unit. One request is in
// flight at a time; a finished result waits in the output register while the
// next request runs. Reset is synchronous; configuration returns to its defaults.
module retry_fallback_sequencer #(
    parameter int MAX_BACKENDS = rfs_pkg::MAX_BACKENDS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  rfs_pkg::rfs_in_t                s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output rfs_pkg::rfs_out_t               m_data,
    input  logic                            cfg_wr_en,
    input  logic [rfs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rfs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int PTR_W = $clog2(MAX_BACKENDS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_PUSH
    } state_t;

    state_t state_reg;

    logic [4:0]  backend_count_reg;
    logic [7:0]  try_limit_reg;
    logic [7:0]  validation_retries_reg;
    logic [31:0] retry_after_cap_reg;
    logic        retry_after_enable_reg;
    logic        retry_after_deltas_reg;
    logic [63:0] prng_seed_reg;

    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic [7:0]       retry_reg, retry_next;
    logic [7:0]       reroll_reg, reroll_next;
    logic [8:0]       try_reg, try_next;
    logic [31:0]      att_reg, att_next;
    logic             any_dlv_reg, any_dlv_next;
    logic [63:0]      rng_reg, rng_next;
    logic [31:0]      req_cnt_reg, req_cnt_next;
    logic             active_reg, active_next;

    logic [63:0] mcand_reg;
    logic [63:0] mplier_reg;
    logic [63:0] acc_reg;
    logic [rfs_pkg::DIG_CNT_W-1:0] dig_cnt_reg;

    rfs_pkg::rfs_out_t pend_reg;
    rfs_pkg::rfs_out_t m_data_reg;
    logic              m_valid_reg;

    rfs_pkg::rfs_out_t res;
    logic              has_res;
    logic              need_mix;
    logic              s_fire;
    logic              out_free;
    logic              dig_last;
    logic [63:0]       pp;
    logic [63:0]       psum;
    logic [63:0]       mix_seed;

    logic             any_dlv;
    logic             blocked;
    logic             advance;
    logic [7:0]       retry_inc;
    logic [PTR_W-1:0] ptr_inc;
    logic [PTR_W-1:0] limit;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign dig_last = (dig_cnt_reg == rfs_pkg::DIG_CNT_W'(rfs_pkg::MUL_DIGITS - 1));
    assign pp       = mcand_reg * 64'(mplier_reg[rfs_pkg::DIGIT_W-1:0]);
    assign psum     = acc_reg + pp;
    assign mix_seed = rng_next ^ (rng_next >> rfs_pkg::MIX_SHIFT0);

    assign limit = (32'(backend_count_reg) < 32'(MAX_BACKENDS))
                 ? PTR_W'(backend_count_reg) : PTR_W'(MAX_BACKENDS);

    always_comb begin
        ptr_next     = ptr_reg;
        retry_next   = retry_reg;
        reroll_next  = reroll_reg;
        try_next     = try_reg;
        att_next     = att_reg;
        any_dlv_next = any_dlv_reg;
        rng_next     = rng_reg;
        req_cnt_next = req_cnt_reg;
        active_next  = active_reg;
        res          = '0;
        res.action   = rfs_pkg::ACT_STARTED;
        res.final_status = rfs_pkg::ST_OK;
        has_res      = 1'b0;
        need_mix     = 1'b0;
        any_dlv      = any_dlv_reg | s_data.delivered;
        blocked      = any_dlv && !retry_after_deltas_reg;
        advance      = 1'b0;
        retry_inc    = (retry_reg != 8'hFF) ? retry_reg + 8'd1 : retry_reg;
        ptr_inc      = ptr_reg + PTR_W'(1);
        if (s_fire) begin
            if (s_data.command == rfs_pkg::CMD_START) begin
                rng_next     = prng_seed_reg ^ 64'(req_cnt_reg);
                req_cnt_next = req_cnt_reg + 32'd1;
                ptr_next     = '0;
                retry_next   = '0;
                reroll_next  = '0;
                try_next     = '0;
                att_next     = '0;
                any_dlv_next = 1'b0;
                active_next  = 1'b1;
                has_res      = 1'b1;
            end else if (active_reg) begin
                has_res = 1'b1;
                res.attempt_number = att_reg;
                res.backend_try    = try_reg;
                res.backend_index  = 4'(ptr_reg);
                res.action         = rfs_pkg::ACT_FINISHED;
                if (att_reg != 32'hFFFF_FFFF) begin
                    att_next = att_reg + 32'd1;
                end
                if (try_reg != 9'h1FF) begin
                    try_next = try_reg + 9'd1;
                end
                any_dlv_next = any_dlv;
                if (s_data.out_of_memory) begin
                    res.final_status = rfs_pkg::ST_NOMEM;
                end else if (s_data.fail_class == rfs_pkg::CLS_SUCCESS) begin
                    res.final_status = rfs_pkg::ST_OK;
                end else if (s_data.fail_class == rfs_pkg::CLS_ABORT) begin
                    res.final_status = rfs_pkg::ST_ABORTED;
                end else if (s_data.fail_class == rfs_pkg::CLS_CANCELLED) begin
                    res.final_status = rfs_pkg::ST_CANCELLED;
                end else if (blocked) begin
                    res.final_status = rfs_pkg::ST_STREAM_LOST;
                end else if (s_data.fail_class == rfs_pkg::CLS_VALIDATOR) begin
                    if (reroll_reg < validation_retries_reg) begin
                        reroll_next = reroll_reg + 8'd1;
                        res.action  = rfs_pkg::ACT_REROLL;
                    end else begin
                        advance = 1'b1;
                    end
                end else if (s_data.fail_class == rfs_pkg::CLS_RETRY) begin
                    retry_next = retry_inc;
                    if (retry_inc >= try_limit_reg) begin
                        advance = 1'b1;
                    end else begin
                        res.action       = rfs_pkg::ACT_WAIT;
                        res.retry_number = retry_inc;
                        if (s_data.retry_after_present && retry_after_enable_reg) begin
                            res.wait_ms = (s_data.server_wait_ms < retry_after_cap_reg)
                                        ? s_data.server_wait_ms : retry_after_cap_reg;
                        end else begin
                            res.backoff_needed = 1'b1;
                            need_mix = 1'b1;
                            rng_next = rng_reg + rfs_pkg::MIX_GOLDEN;
                        end
                    end
                end else begin
                    advance = 1'b1;
                end
                if (advance) begin
                    ptr_next = ptr_inc;
                    if (ptr_inc >= limit) begin
                        res.action       = rfs_pkg::ACT_FINISHED;
                        res.final_status = rfs_pkg::ST_EXHAUSTED;
                    end else begin
                        retry_next        = '0;
                        reroll_next       = '0;
                        try_next          = '0;
                        res.action        = rfs_pkg::ACT_NEXT;
                        res.backend_index = 4'(ptr_inc);
                    end
                end
                if (res.action == rfs_pkg::ACT_FINISHED) begin
                    active_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            backend_count_reg      <= rfs_pkg::BACKEND_COUNT_RST;
            try_limit_reg          <= rfs_pkg::TRY_LIMIT_RST;
            validation_retries_reg <= rfs_pkg::VALIDATION_RETRIES_RST;
            retry_after_cap_reg    <= rfs_pkg::RETRY_AFTER_CAP_RST;
            retry_after_enable_reg <= rfs_pkg::RETRY_AFTER_ENABLE_RST;
            retry_after_deltas_reg <= rfs_pkg::RETRY_AFTER_DELTAS_RST;
            prng_seed_reg          <= rfs_pkg::PRNG_SEED_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rfs_pkg::CFG_BACKEND_COUNT:      backend_count_reg <= cfg_wdata[4:0];
                rfs_pkg::CFG_TRY_LIMIT:          try_limit_reg <= cfg_wdata[7:0];
                rfs_pkg::CFG_VALIDATION_RETRIES: validation_retries_reg <= cfg_wdata[7:0];
                rfs_pkg::CFG_RETRY_AFTER_CAP_MS: retry_after_cap_reg <= cfg_wdata[31:0];
                rfs_pkg::CFG_RETRY_AFTER_ENABLE: retry_after_enable_reg <= cfg_wdata[0];
                rfs_pkg::CFG_RETRY_AFTER_DELTAS: retry_after_deltas_reg <= cfg_wdata[0];
                rfs_pkg::CFG_PRNG_SEED:          prng_seed_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            ptr_reg     <= '0;
            retry_reg   <= '0;
            reroll_reg  <= '0;
            try_reg     <= '0;
            att_reg     <= '0;
            any_dlv_reg <= 1'b0;
            rng_reg     <= '0;
            req_cnt_reg <= '0;
            active_reg  <= 1'b0;
            dig_cnt_reg <= '0;
        end else begin
            ptr_reg     <= ptr_next;
            retry_reg   <= retry_next;
            reroll_reg  <= reroll_next;
            try_reg     <= try_next;
            att_reg     <= att_next;
            any_dlv_reg <= any_dlv_next;
            rng_reg     <= rng_next;
            req_cnt_reg <= req_cnt_next;
            active_reg  <= active_next;
            if (state_reg == S_PUSH && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_fire && has_res) begin
                        pend_reg <= res;
                        if (need_mix) begin
                            mcand_reg   <= mix_seed;
                            mplier_reg  <= rfs_pkg::MIX_MUL1;
                            acc_reg     <= '0;
                            dig_cnt_reg <= '0;
                            state_reg   <= S_MUL1;
                        end else begin
                            state_reg <= S_PUSH;
                        end
                    end
                end
                S_MUL1: begin
                    dig_cnt_reg <= dig_cnt_reg + rfs_pkg::DIG_CNT_W'(1);
                    if (dig_last) begin
                        mcand_reg  <= psum ^ (psum >> rfs_pkg::MIX_SHIFT1);
                        mplier_reg <= rfs_pkg::MIX_MUL2;
                        acc_reg    <= '0;
                        state_reg  <= S_MUL2;
                    end else begin
                        mcand_reg  <= mcand_reg << rfs_pkg::DIGIT_W;
                        mplier_reg <= mplier_reg >> rfs_pkg::DIGIT_W;
                        acc_reg    <= psum;
                    end
                end
                S_MUL2: begin
                    dig_cnt_reg <= dig_cnt_reg + rfs_pkg::DIG_CNT_W'(1);
                    mcand_reg   <= mcand_reg << rfs_pkg::DIGIT_W;
                    mplier_reg  <= mplier_reg >> rfs_pkg::DIGIT_W;
                    acc_reg     <= psum;
                    if (dig_last) begin
                        pend_reg.jitter_word <= psum ^ (psum >> rfs_pkg::MIX_SHIFT2);
                        state_reg <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (out_free) begin
                        m_data_reg  <= pend_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_backoff_no_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.backoff_needed
        |-> m_data.action == rfs_pkg::ACT_WAIT && m_data.wait_ms == 32'd0)
        else $error("backoff result with a wait or wrong action");

    a_status_only_finished: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.action != rfs_pkg::ACT_FINISHED
        |-> m_data.final_status == rfs_pkg::ST_OK)
        else $error("status set on an unfinished result");

    a_jitter_only_backoff: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.backoff_needed |-> m_data.jitter_word == 64'd0)
        else $error("jitter word without backoff");

    a_start_opens: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.command == rfs_pkg::CMD_START
        |=> active_reg && att_reg == 32'd0)
        else $error("start did not open a request");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for retry_fallback_sequencer: an in-bench predictor
// tracks request state and jitter generator. Depends on rfs_pkg and the RTL.
module tb_top;

    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_REQUESTS = 325;

    typedef struct {
        logic [4:0]  backends;
        logic [7:0]  tries;
        logic [7:0]  rerolls;
        logic [31:0] cap_ms;
        logic        ra_enable;
        logic        ra_deltas;
        logic [63:0] seed;
    } rfs_settings_t;

    class rfs_scoreboard;
        rfs_pkg::rfs_out_t expected_q[$];
        int          errors;

        logic [4:0]  backend_count;
        logic [7:0]  try_limit;
        logic [7:0]  reroll_budget;
        logic [31:0] cap_ms;
        logic        ra_enable;
        logic        deltas_ok;
        logic [63:0] seed;

        logic [4:0]  backend_ptr;
        logic [7:0]  retries;
        logic [7:0]  rerolls;
        logic [8:0]  try_count;
        logic [31:0] attempt_count;
        logic        delivered_seen;
        logic [63:0] rng_state;
        logic [31:0] request_count;
        logic        request_active;

        function new();
            errors = 0;
            backend_count = rfs_pkg::BACKEND_COUNT_RST;
            try_limit = rfs_pkg::TRY_LIMIT_RST;
            reroll_budget = rfs_pkg::VALIDATION_RETRIES_RST;
            cap_ms = rfs_pkg::RETRY_AFTER_CAP_RST;
            ra_enable = rfs_pkg::RETRY_AFTER_ENABLE_RST;
            deltas_ok = rfs_pkg::RETRY_AFTER_DELTAS_RST;
            seed = rfs_pkg::PRNG_SEED_RST;
            backend_ptr = '0;
            clear_backend();
            attempt_count = '0;
            delivered_seen = 1'b0;
            rng_state = '0;
            request_count = '0;
            request_active = 1'b0;
        endfunction

        function void clear_backend();
            retries = '0;
            rerolls = '0;
            try_count = '0;
        endfunction

        function void write_reg(logic [rfs_pkg::CFG_IDX_W-1:0] idx, logic [63:0] value);
            case (idx)
                rfs_pkg::CFG_BACKEND_COUNT: backend_count = value[4:0];
                rfs_pkg::CFG_TRY_LIMIT: try_limit = value[7:0];
                rfs_pkg::CFG_VALIDATION_RETRIES: reroll_budget = value[7:0];
                rfs_pkg::CFG_RETRY_AFTER_CAP_MS: cap_ms = value[31:0];
                rfs_pkg::CFG_RETRY_AFTER_ENABLE: ra_enable = value[0];
                rfs_pkg::CFG_RETRY_AFTER_DELTAS: deltas_ok = value[0];
                rfs_pkg::CFG_PRNG_SEED: seed = value;
                default: ;
            endcase
        endfunction

        function logic [63:0] next_jitter();
            logic [63:0] z;
            rng_state = rng_state + rfs_pkg::MIX_GOLDEN;
            z = rng_state;
            z = (z ^ (z >> rfs_pkg::MIX_SHIFT0)) * rfs_pkg::MIX_MUL1;
            z = (z ^ (z >> rfs_pkg::MIX_SHIFT1)) * rfs_pkg::MIX_MUL2;
            return z ^ (z >> rfs_pkg::MIX_SHIFT2);
        endfunction

        function void note_request(rfs_pkg::rfs_in_t req);
            rfs_pkg::rfs_out_t res;
            int       limit;
            logic     advance;
            logic     blocked;
            res = '0;
            if (req.command == rfs_pkg::CMD_START) begin
                rng_state = seed ^ {32'd0, request_count};
                request_count = request_count + 32'd1;
                backend_ptr = '0;
                clear_backend();
                attempt_count = '0;
                delivered_seen = 1'b0;
                request_active = 1'b1;
                res.action = rfs_pkg::ACT_STARTED;
                expected_q.push_back(res);
                return;
            end
            if (!request_active)
                return;

            res.attempt_number = attempt_count;
            if (attempt_count != 32'hFFFF_FFFF)
                attempt_count = attempt_count + 32'd1;
            res.backend_try = try_count;
            if (try_count < 9'd511)
                try_count = try_count + 9'd1;
            delivered_seen = delivered_seen | req.delivered;
            res.backend_index = backend_ptr[3:0];
            res.action = rfs_pkg::ACT_FINISHED;
            res.final_status = rfs_pkg::ST_OK;
            blocked = delivered_seen && !deltas_ok;
            advance = 1'b0;

            if (req.out_of_memory) begin
                res.final_status = rfs_pkg::ST_NOMEM;
            end else if (req.fail_class == rfs_pkg::CLS_SUCCESS) begin
                res.final_status = rfs_pkg::ST_OK;
            end else if (req.fail_class == rfs_pkg::CLS_ABORT) begin
                res.final_status = rfs_pkg::ST_ABORTED;
            end else if (req.fail_class == rfs_pkg::CLS_CANCELLED) begin
                res.final_status = rfs_pkg::ST_CANCELLED;
            end else if (blocked) begin
                res.final_status = rfs_pkg::ST_STREAM_LOST;
            end else if (req.fail_class == rfs_pkg::CLS_VALIDATOR) begin
                if (rerolls < reroll_budget) begin
                    rerolls = rerolls + 8'd1;
                    res.action = rfs_pkg::ACT_REROLL;
                end else begin
                    advance = 1'b1;
                end
            end else if (req.fail_class == rfs_pkg::CLS_RETRY) begin
                if (retries != 8'd255)
                    retries = retries + 8'd1;
                if (retries >= try_limit) begin
                    advance = 1'b1;
                end else begin
                    res.action = rfs_pkg::ACT_WAIT;
                    res.retry_number = retries;
                    if (req.retry_after_present && ra_enable) begin
                        res.wait_ms = (req.server_wait_ms < cap_ms) ? req.server_wait_ms
                                                                     : cap_ms;
                    end else begin
                        res.backoff_needed = 1'b1;
                        res.jitter_word = next_jitter();
                    end
                end
            end else begin
                advance = 1'b1;
            end

            if (advance) begin
                limit = (int'(backend_count) < rfs_pkg::MAX_BACKENDS_DEF)
                      ? int'(backend_count) : rfs_pkg::MAX_BACKENDS_DEF;
                backend_ptr = backend_ptr + 5'd1;
                if (int'(backend_ptr) >= limit) begin
                    res.action = rfs_pkg::ACT_FINISHED;
                    res.final_status = rfs_pkg::ST_EXHAUSTED;
                end else begin
                    clear_backend();
                    res.action = rfs_pkg::ACT_NEXT;
                    res.backend_index = backend_ptr[3:0];
                end
            end
            if (res.action == rfs_pkg::ACT_FINISHED)
                request_active = 1'b0;
            expected_q.push_back(res);
        endfunction

        task report(string msg);
            if (errors < 100)
                $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(rfs_pkg::rfs_out_t got);
            rfs_pkg::rfs_out_t exp;
            if (expected_q.size() == 0) begin
                report($sformatf("result with nothing pending, action %0d", got.action));
                return;
            end
            exp = expected_q.pop_front();
            if (got.action !== exp.action)
                report($sformatf("action %0d, want %0d", got.action, exp.action));
            if (got.final_status !== exp.final_status)
                report($sformatf("final_status %0d, want %0d", got.final_status,
                                 exp.final_status));
            if (got.backend_index !== exp.backend_index)
                report($sformatf("backend_index %0d, want %0d", got.backend_index,
                                 exp.backend_index));
            if (got.attempt_number !== exp.attempt_number)
                report($sformatf("attempt_number %0d, want %0d", got.attempt_number,
                                 exp.attempt_number));
            if (got.backend_try !== exp.backend_try)
                report($sformatf("backend_try %0d, want %0d", got.backend_try,
                                 exp.backend_try));
            if (got.wait_ms !== exp.wait_ms)
                report($sformatf("wait_ms %0d, want %0d", got.wait_ms, exp.wait_ms));
            if (got.backoff_needed !== exp.backoff_needed)
                report($sformatf("backoff_needed %0b, want %0b", got.backoff_needed,
                                 exp.backoff_needed));
            if (got.retry_number !== exp.retry_number)
                report($sformatf("retry_number %0d, want %0d", got.retry_number,
                                 exp.retry_number));
            if (got.jitter_word !== exp.jitter_word)
                report($sformatf("jitter_word %h, want %h", got.jitter_word,
                                 exp.jitter_word));
        endtask
    endclass

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    rfs_pkg::rfs_in_t               s_data = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    rfs_pkg::rfs_out_t              m_data;
    logic                           cfg_wr_en = 1'b0;
    logic [rfs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [rfs_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    rfs_scoreboard sb;
    int            tx_idle_pct = 7;
    int            rx_idle_pct = 57;
    bit            calm = 1'b0;
    int            stall_cycles = 0;

    retry_fallback_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_data);
    end

    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic send_request(rfs_pkg::rfs_in_t req);
        while (!calm && $urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= req;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(req);
    endtask

    task automatic write_reg(logic [rfs_pkg::CFG_IDX_W-1:0] idx, logic [63:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.write_reg(idx, value);
    endtask

    task automatic apply_settings(rfs_settings_t cfg);
        write_reg(rfs_pkg::CFG_BACKEND_COUNT, 64'(cfg.backends));
        write_reg(rfs_pkg::CFG_TRY_LIMIT, 64'(cfg.tries));
        write_reg(rfs_pkg::CFG_VALIDATION_RETRIES, 64'(cfg.rerolls));
        write_reg(rfs_pkg::CFG_RETRY_AFTER_CAP_MS, 64'(cfg.cap_ms));
        write_reg(rfs_pkg::CFG_RETRY_AFTER_ENABLE, 64'(cfg.ra_enable));
        write_reg(rfs_pkg::CFG_RETRY_AFTER_DELTAS, 64'(cfg.ra_deltas));
        write_reg(rfs_pkg::CFG_PRNG_SEED, cfg.seed);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic rfs_pkg::rfs_in_t outcome(logic [2:0] cls, logic oom, logic dlv,
                                                 logic present, logic [31:0] ms);
        rfs_pkg::rfs_in_t req;
        req.command = rfs_pkg::CMD_OUTCOME;
        req.fail_class = cls;
        req.out_of_memory = oom;
        req.delivered = dlv;
        req.retry_after_present = present;
        req.server_wait_ms = ms;
        return req;
    endfunction

    function automatic rfs_pkg::rfs_in_t start_cmd();
        rfs_pkg::rfs_in_t req;
        req = '0;
        req.command = rfs_pkg::CMD_START;
        return req;
    endfunction

    function automatic rfs_pkg::rfs_in_t random_request(bit active);
        rfs_pkg::rfs_in_t req;
        int      pick;
        logic [2:0] cls;
        pick = $urandom_range(99);
        if (pick < 35)
            cls = rfs_pkg::CLS_RETRY;
        else if (pick < 50)
            cls = rfs_pkg::CLS_VALIDATOR;
        else if (pick < 65)
            cls = rfs_pkg::CLS_ADVANCE;
        else if (pick < 77)
            cls = rfs_pkg::CLS_SUCCESS;
        else if (pick < 83)
            cls = rfs_pkg::CLS_ABORT;
        else if (pick < 89)
            cls = rfs_pkg::CLS_CANCELLED;
        else
            cls = 3'($urandom_range(7));
        req = outcome(cls, $urandom_range(99) < 4, $urandom_range(99) < 6,
                      1'($urandom_range(1)), $urandom);
        case ($urandom_range(3))
            0: req.server_wait_ms = $urandom_range(5000);
            1: req.server_wait_ms = $urandom_range(70000, 50000);
            2: req.server_wait_ms = $urandom_range(1) ? 32'd0 : 32'hFFFF_FFFF;
            default: ;
        endcase
        pick = $urandom_range(99);
        if (active ? (pick < 4) : (pick < 90))
            req.command = rfs_pkg::CMD_START;
        return req;
    endfunction

    initial begin
        rfs_settings_t    plan[6];
        rfs_pkg::rfs_in_t req;
        int               counted;

        sb = new();
        plan[0] = '{5'd4, 8'd3, 8'd2, 32'd5000, 1'b1, 1'b0, {$urandom, $urandom}};
        plan[1] = '{5'd16, 8'd255, 8'd255, 32'hFFFF_FFFF, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF};
        plan[2] = '{5'd0, 8'd0, 8'd0, 32'd0, 1'b0, 1'b0, 64'd0};
        plan[3] = '{5'd31, 8'd1, 8'd1, 32'd0, 1'b1, 1'b1, {$urandom, $urandom}};
        plan[4] = '{5'd2, 8'd5, 8'd3, 32'd1000, 1'b0, 1'b1, {$urandom, $urandom}};
        plan[5] = '{5'd8, 8'd4, 8'd1, $urandom, 1'b1, 1'b0, {$urandom, $urandom}};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // outcome with no open request, then defaults: single backend, three tries
        send_request(outcome(rfs_pkg::CLS_RETRY, 1'b0, 1'b0, 1'b1, 32'd7));
        send_request(start_cmd());
        send_request(outcome(rfs_pkg::CLS_RETRY, 1'b0, 1'b0, 1'b1, 32'd100));
        send_request(outcome(rfs_pkg::CLS_RETRY, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF));
        send_request(outcome(rfs_pkg::CLS_RETRY, 1'b0, 1'b0, 1'b0, 32'd0));
        send_request(start_cmd());
        send_request(outcome(rfs_pkg::CLS_RETRY, 1'b0, 1'b0, 1'b0, 32'd0));
        send_request(outcome(rfs_pkg::CLS_VALIDATOR, 1'b0, 1'b0, 1'b0, 32'd0));
        send_request(start_cmd());
        send_request(outcome(rfs_pkg::CLS_SUCCESS, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF));
        send_request(start_cmd());
        send_request(outcome(rfs_pkg::CLS_ABORT, 1'b0, 1'b0, 1'b0, 32'd0));
        send_request(start_cmd());
        send_request(outcome(rfs_pkg::CLS_CANCELLED, 1'b0, 1'b0, 1'b0, 32'd0));
        send_request(start_cmd());
        send_request(start_cmd());
        send_request(outcome(3'd7, 1'b0, 1'b0, 1'b0, 32'd0));
        send_request(start_cmd());
        send_request(outcome(rfs_pkg::CLS_RETRY, 1'b1, 1'b0, 1'b1, 32'd5));
        send_request(start_cmd());
        send_request(outcome(rfs_pkg::CLS_RETRY, 1'b0, 1'b1, 1'b1, 32'd5));
        send_request(start_cmd());
        send_request(outcome(3'd6, 1'b0, 1'b0, 1'b0, 32'd0));

        for (int phase = 0; phase < 6; phase++) begin
            wait_drained();
            apply_settings(plan[phase]);
            case (phase / 2)
                0: begin
                    tx_idle_pct = 7;
                    rx_idle_pct = 57;
                end
                1: begin
                    tx_idle_pct = 57;
                    rx_idle_pct = 7;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            counted = 0;
            while (counted < PHASE_REQUESTS) begin
                req = random_request(sb.request_active);
                if (req.command == rfs_pkg::CMD_START || sb.request_active)
                    counted++;
                calm = ((counted / 40) % 4) == 3;
                send_request(req);
            end
            calm = 1'b0;
        end

        wait_drained();
        if (sb.expected_q.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
